### rtl/rlms_pkg.sv
// package for the radio link mode sequencer
// mode codes, status bit positions, register indexes and reset values; no dependencies
`timescale 1ns / 1ps

package rlms_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned REG_W  = 16;
    localparam int unsigned IRQ_W  = 10;
    localparam int unsigned MODE_W = 3;
    localparam int unsigned IDX_W  = 3;

    // radio modes
    localparam logic [MODE_W-1:0] MODE_IDLE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BUSY = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RX   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TX   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CAD  = 3'd4;

    // status bit positions
    localparam int unsigned B_PREAMBLE  = 0;
    localparam int unsigned B_RXDONE    = 1;
    localparam int unsigned B_HDRVALID  = 2;
    localparam int unsigned B_CRCERR    = 3;
    localparam int unsigned B_HDRERR    = 4;
    localparam int unsigned B_RXTIMEOUT = 5;
    localparam int unsigned B_TXDONE    = 6;
    localparam int unsigned B_TXTIMEOUT = 7;
    localparam int unsigned B_ACTIVITY  = 8;
    localparam int unsigned B_CADDONE   = 9;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_RX_RESTART  = 3'd0;
    localparam logic [IDX_W-1:0] REG_TX_TIMEOUT  = 3'd1;
    localparam logic [IDX_W-1:0] REG_BUSY_TMO    = 3'd2;
    localparam logic [IDX_W-1:0] REG_TX_GUARD    = 3'd3;
    localparam logic [IDX_W-1:0] REG_CAD_RX_TMO  = 3'd4;
    localparam logic [IDX_W-1:0] REG_DEF_RX_TMO  = 3'd5;

    localparam logic [REG_W-1:0] RST_RX_RESTART = 16'd500;
    localparam logic [REG_W-1:0] RST_TX_TIMEOUT = 16'd500;
    localparam logic [REG_W-1:0] RST_BUSY_TMO   = 16'd500;
    localparam logic [REG_W-1:0] RST_TX_GUARD   = 16'd1;

    typedef logic [MODE_W-1:0] t_mode;

    // true when the wrapped age now - then exceeds limit
    function automatic logic older_than(input logic [TIME_W-1:0] now,
                                        input logic [TIME_W-1:0] then_t,
                                        input logic [REG_W-1:0]  limit);
        logic [TIME_W-1:0] age;
        age = now - then_t;
        return (age > {{(TIME_W-REG_W){1'b0}}, limit});
    endfunction

endpackage

### rtl/radio_link_mode_sequencer.sv
// top level of the radio link mode sequencer
// input register, one-pass mode logic, output register; uses rlms_pkg
`timescale 1ns / 1ps

// Takes one service event per beat and returns one result beat per event. An event
// is captured in the input register, evaluated combinationally against the mode and
// timestamp state, and the result lands in the output register, so events are
// accepted back to back at one per cycle while the result side does not stall. A
// stall on the result side holds the output register and the input register behind
// it. The two receive timeout registers are accepted on the write port but only the
// choice of timeout is reported, through rx_long_timeout.
module radio_link_mode_sequencer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // event channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [rlms_pkg::TIME_W-1:0]  i_now_ms,
    input  logic                         i_irq_line,
    input  logic [rlms_pkg::IRQ_W-1:0]   i_irq_bits,
    input  logic                         i_tx_pending,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [rlms_pkg::MODE_W-1:0]  o_new_mode,
    output logic [rlms_pkg::IRQ_W-1:0]   o_clear_bits,
    output logic                         o_read_packet,
    output logic                         o_start_cad,
    output logic                         o_start_tx,
    output logic                         o_start_rx,
    output logic                         o_rx_long_timeout,
    // configuration writes
    input  logic                         i_cfg_we,
    input  logic [rlms_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [rlms_pkg::REG_W-1:0]   i_cfg_data
);
    import rlms_pkg::*;

    // configuration
    logic [REG_W-1:0]  r_rx_restart, r_tx_timeout, r_busy_tmo, r_tx_guard;

    // input stage
    logic              r_in_valid;
    logic [TIME_W-1:0] r_now;
    logic              r_line;
    logic [IRQ_W-1:0]  r_bits;
    logic              r_pending;

    // state
    t_mode             r_mode;
    logic [TIME_W-1:0] r_busy_start, r_rx_start, r_tx_start, r_tx_end;

    // output stage
    logic              r_out_valid;
    t_mode             r_new_mode;
    logic [IRQ_W-1:0]  r_clear_bits;
    logic              r_rd, r_cad, r_tx, r_rx, r_lng;

    // step results
    t_mode             n_mode;
    logic [IRQ_W-1:0]  n_clr;
    logic              n_rd, n_cad, n_tx, n_rx, n_lng;
    logic              upd_busy, upd_rx, upd_txs, upd_txe;

    logic              out_move, step;

    assign out_move   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_move;
    assign o_in_stall = r_in_valid && !out_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_restart <= RST_RX_RESTART;
            r_tx_timeout <= RST_TX_TIMEOUT;
            r_busy_tmo   <= RST_BUSY_TMO;
            r_tx_guard   <= RST_TX_GUARD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RX_RESTART: r_rx_restart <= i_cfg_data;
                REG_TX_TIMEOUT: r_tx_timeout <= i_cfg_data;
                REG_BUSY_TMO:   r_busy_tmo   <= i_cfg_data;
                REG_TX_GUARD:   r_tx_guard   <= i_cfg_data;
                // timeout values themselves are not needed downstream
                REG_CAD_RX_TMO, REG_DEF_RX_TMO: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_now     <= i_now_ms;
            r_line    <= i_irq_line;
            r_bits    <= i_irq_bits;
            r_pending <= i_tx_pending;
        end
    end

    // timestamps written this step give an age of zero, which never exceeds a limit
    always_comb begin
        n_mode   = r_mode;
        n_clr    = '0;
        n_rd     = 1'b0;
        n_cad    = 1'b0;
        n_tx     = 1'b0;
        n_rx     = 1'b0;
        n_lng    = 1'b0;
        upd_busy = 1'b0;
        upd_rx   = 1'b0;
        upd_txs  = 1'b0;
        upd_txe  = 1'b0;

        if (r_line) begin
            if (r_bits[B_PREAMBLE]) begin
                n_mode = MODE_BUSY;
                upd_busy = 1'b1;
                n_clr[B_PREAMBLE] = 1'b1;
            end
            if (r_bits[B_RXDONE] && r_bits[B_HDRVALID] && !r_bits[B_CRCERR]) begin
                n_rd = 1'b1;
                n_mode = MODE_IDLE;
                n_clr[B_RXDONE]   = 1'b1;
                n_clr[B_HDRVALID] = 1'b1;
                n_clr[B_PREAMBLE] = 1'b1;
            end
            if (r_bits[B_HDRERR]) begin
                n_mode = MODE_IDLE;
                n_clr[B_HDRERR] = 1'b1;
            end
            if (r_bits[B_CRCERR]) begin
                n_mode = MODE_IDLE;
                n_clr[B_CRCERR] = 1'b1;
            end
            if (r_bits[B_RXTIMEOUT]) begin
                n_mode = MODE_IDLE;
                n_clr[B_RXTIMEOUT] = 1'b1;
            end
            if (r_bits[B_TXDONE]) begin
                n_mode = MODE_IDLE;
                upd_txe = 1'b1;
                n_clr[B_TXDONE] = 1'b1;
            end
            if (r_bits[B_TXTIMEOUT]) begin
                n_mode = MODE_IDLE;
                upd_txe = 1'b1;
                n_clr[B_TXTIMEOUT] = 1'b1;
            end
            if (r_bits[B_ACTIVITY]) begin
                n_mode = MODE_RX;
                upd_busy = 1'b1;
                n_rx = 1'b1;
                n_lng = 1'b1;
                n_clr[B_ACTIVITY] = 1'b1;
            end
            if (r_bits[B_CADDONE]) begin
                n_clr[B_CADDONE] = 1'b1;
                n_mode = MODE_IDLE;
                if (r_pending) begin
                    n_tx = 1'b1;
                    n_mode = MODE_TX;
                    upd_txs = 1'b1;
                end
            end
        end

        if (r_pending && (n_mode == MODE_IDLE || n_mode == MODE_RX) && !upd_txe
            && older_than(r_now, r_tx_end, r_tx_guard)) begin
            n_mode = MODE_CAD;
            n_cad = 1'b1;
        end
        if (n_mode == MODE_IDLE) begin
            n_mode = MODE_RX;
            n_rx = 1'b1;
            n_lng = 1'b0;
            upd_rx = 1'b1;
        end
        if (n_mode == MODE_RX && !upd_rx
            && older_than(r_now, r_rx_start, r_rx_restart)) begin
            n_rx = 1'b1;
            n_lng = 1'b0;
            upd_rx = 1'b1;
        end
        if (n_mode == MODE_TX && !upd_txs
            && older_than(r_now, r_tx_start, r_tx_timeout)) begin
            n_mode = MODE_IDLE;
        end
        if ((n_mode == MODE_BUSY || n_mode == MODE_CAD) && !upd_busy
            && older_than(r_now, r_busy_start, r_busy_tmo)) begin
            n_mode = MODE_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_busy_start <= '0;
            r_rx_start   <= '0;
            r_tx_start   <= '0;
            r_tx_end     <= '0;
        end else if (step) begin
            r_mode <= n_mode;
            if (upd_busy) r_busy_start <= r_now;
            if (upd_rx)   r_rx_start   <= r_now;
            if (upd_txs)  r_tx_start   <= r_now;
            if (upd_txe)  r_tx_end     <= r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_move) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_new_mode   <= n_mode;
            r_clear_bits <= n_clr;
            r_rd         <= n_rd;
            r_cad        <= n_cad;
            r_tx         <= n_tx;
            r_rx         <= n_rx;
            r_lng        <= n_rx && n_lng;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_new_mode        = r_new_mode;
    assign o_clear_bits      = r_clear_bits;
    assign o_read_packet     = r_rd;
    assign o_start_cad       = r_cad;
    assign o_start_tx        = r_tx;
    assign o_start_rx        = r_rx;
    assign o_rx_long_timeout = r_lng;

endmodule

### rtl/rlms_checker.sv
// port-level checks for the radio link mode sequencer, bound to the top level
// uses rlms_pkg for mode codes and status bit positions
`timescale 1ns / 1ps

module rlms_port_asserts (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [rlms_pkg::MODE_W-1:0]  o_new_mode,
    input logic [rlms_pkg::IRQ_W-1:0]   o_clear_bits,
    input logic                         o_read_packet,
    input logic                         o_start_tx,
    input logic                         o_start_rx,
    input logic                         o_rx_long_timeout
);
    import rlms_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_new_mode)
        && $stable(o_clear_bits) && $stable(o_start_rx))
        else $error("stalled result beat changed");

    a_long_needs_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rx_long_timeout |-> o_start_rx)
        else $error("long timeout flagged without receive start");

    // a fresh transmit start cannot time out in the same beat
    a_tx_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_start_tx |-> o_new_mode == MODE_TX)
        else $error("transmit start without transmitting mode");

    a_read_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_packet |-> o_clear_bits[B_RXDONE]
        && o_clear_bits[B_HDRVALID] && o_clear_bits[B_PREAMBLE])
        else $error("packet read without clearing rx bits");

endmodule

bind radio_link_mode_sequencer rlms_port_asserts u_rlms_port_asserts (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_new_mode        (o_new_mode),
    .o_clear_bits      (o_clear_bits),
    .o_read_packet     (o_read_packet),
    .o_start_tx        (o_start_tx),
    .o_start_rx        (o_start_rx),
    .o_rx_long_timeout (o_rx_long_timeout)
);

### dv/rlms_checker.sv
// result checker for the radio link mode sequencer
// watches the event, result and register write ports and predicts every result beat; uses rlms_pkg
`timescale 1ns / 1ps

module rlms_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // event channel
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [rlms_pkg::TIME_W-1:0]  i_now_ms,
    input  logic                         i_irq_line,
    input  logic [rlms_pkg::IRQ_W-1:0]   i_irq_bits,
    input  logic                         i_tx_pending,
    // result channel
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [rlms_pkg::MODE_W-1:0]  i_new_mode,
    input  logic [rlms_pkg::IRQ_W-1:0]   i_clear_bits,
    input  logic                         i_read_packet,
    input  logic                         i_start_cad,
    input  logic                         i_start_tx,
    input  logic                         i_start_rx,
    input  logic                         i_rx_long_timeout,
    // register writes
    input  logic                         i_cfg_we,
    input  logic [rlms_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [rlms_pkg::REG_W-1:0]   i_cfg_data,
    // status for the testbench top
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_checked
);

    import rlms_pkg::*;

    typedef struct packed {
        t_mode             new_mode;
        logic [IRQ_W-1:0]  clear_bits;
        logic              read_packet;
        logic              start_cad;
        logic              start_tx;
        logic              start_rx;
        logic              rx_long_timeout;
    } t_mode_result;

    // mirrored mode and timestamps
    t_mode              cur_mode;
    logic [TIME_W-1:0]  busy_since;
    logic [TIME_W-1:0]  rx_since;
    logic [TIME_W-1:0]  tx_since;
    logic [TIME_W-1:0]  tx_done_at;

    // mirrored registers
    logic [REG_W-1:0]   rx_restart_lim;
    logic [REG_W-1:0]   tx_timeout_lim;
    logic [REG_W-1:0]   busy_timeout_lim;
    logic [REG_W-1:0]   tx_guard_lim;

    t_mode_result       expected_results[$];
    t_mode_result       want;
    t_mode_result       got;
    int                 fail_count = 0;
    int                 checked = 0;

    assign o_fail_count = fail_count;
    assign o_checked    = checked;

    function automatic logic aged_past(input logic [TIME_W-1:0] now,
                                       input logic [TIME_W-1:0] since,
                                       input logic [REG_W-1:0]  lim);
        logic [TIME_W-1:0] age;
        age = now - since;
        return age > {{(TIME_W-REG_W){1'b0}}, lim};
    endfunction

    // one service event against the mirrored state
    function automatic t_mode_result sequence_event(input logic [TIME_W-1:0] now,
                                                    input logic             line,
                                                    input logic [IRQ_W-1:0] bits,
                                                    input logic             pending);
        t_mode_result r;
        r = '0;
        if (line) begin
            if (bits[B_PREAMBLE]) begin
                cur_mode = MODE_BUSY;
                busy_since = now;
                r.clear_bits[B_PREAMBLE] = 1'b1;
            end
            if (bits[B_RXDONE] && bits[B_HDRVALID] && !bits[B_CRCERR]) begin
                r.read_packet = 1'b1;
                cur_mode = MODE_IDLE;
                r.clear_bits[B_RXDONE]   = 1'b1;
                r.clear_bits[B_HDRVALID] = 1'b1;
                r.clear_bits[B_PREAMBLE] = 1'b1;
            end
            if (bits[B_HDRERR]) begin
                cur_mode = MODE_IDLE;
                r.clear_bits[B_HDRERR] = 1'b1;
            end
            if (bits[B_CRCERR]) begin
                cur_mode = MODE_IDLE;
                r.clear_bits[B_CRCERR] = 1'b1;
            end
            if (bits[B_RXTIMEOUT]) begin
                cur_mode = MODE_IDLE;
                r.clear_bits[B_RXTIMEOUT] = 1'b1;
            end
            if (bits[B_TXDONE]) begin
                cur_mode = MODE_IDLE;
                tx_done_at = now;
                r.clear_bits[B_TXDONE] = 1'b1;
            end
            if (bits[B_TXTIMEOUT]) begin
                cur_mode = MODE_IDLE;
                tx_done_at = now;
                r.clear_bits[B_TXTIMEOUT] = 1'b1;
            end
            // activity moves busy_since but leaves rx_since alone
            if (bits[B_ACTIVITY]) begin
                cur_mode = MODE_RX;
                busy_since = now;
                r.start_rx = 1'b1;
                r.rx_long_timeout = 1'b1;
                r.clear_bits[B_ACTIVITY] = 1'b1;
            end
            if (bits[B_CADDONE]) begin
                r.clear_bits[B_CADDONE] = 1'b1;
                cur_mode = MODE_IDLE;
                if (pending) begin
                    r.start_tx = 1'b1;
                    cur_mode = MODE_TX;
                    tx_since = now;
                end
            end
        end

        if (pending && (cur_mode == MODE_IDLE || cur_mode == MODE_RX) &&
            aged_past(now, tx_done_at, tx_guard_lim)) begin
            cur_mode = MODE_CAD;
            r.start_cad = 1'b1;
        end
        if (cur_mode == MODE_IDLE) begin
            cur_mode = MODE_RX;
            r.start_rx = 1'b1;
            r.rx_long_timeout = 1'b0;
            rx_since = now;
        end
        if (cur_mode == MODE_RX && aged_past(now, rx_since, rx_restart_lim)) begin
            r.start_rx = 1'b1;
            r.rx_long_timeout = 1'b0;
            rx_since = now;
        end
        // timeouts back to idle do not start a receive until the next event
        if (cur_mode == MODE_TX && aged_past(now, tx_since, tx_timeout_lim))
            cur_mode = MODE_IDLE;
        if ((cur_mode == MODE_BUSY || cur_mode == MODE_CAD) &&
            aged_past(now, busy_since, busy_timeout_lim))
            cur_mode = MODE_IDLE;

        r.new_mode = cur_mode;
        r.rx_long_timeout = r.rx_long_timeout & r.start_rx;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_mode         = MODE_IDLE;
            busy_since       = '0;
            rx_since         = '0;
            tx_since         = '0;
            tx_done_at       = '0;
            rx_restart_lim   = RST_RX_RESTART;
            tx_timeout_lim   = RST_TX_TIMEOUT;
            busy_timeout_lim = RST_BUSY_TMO;
            tx_guard_lim     = RST_TX_GUARD;
            expected_results.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RX_RESTART: rx_restart_lim   = i_cfg_data;
                    REG_TX_TIMEOUT: tx_timeout_lim   = i_cfg_data;
                    REG_BUSY_TMO:   busy_timeout_lim = i_cfg_data;
                    REG_TX_GUARD:   tx_guard_lim     = i_cfg_data;
                    // receive timeout values are not mirrored; only the choice of timeout is reported
                    REG_CAD_RX_TMO, REG_DEF_RX_TMO: ;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(
                    sequence_event(i_now_ms, i_irq_line, i_irq_bits, i_tx_pending));
            if (i_out_valid && !i_out_stall) begin
                got.new_mode        = i_new_mode;
                got.clear_bits      = i_clear_bits;
                got.read_packet     = i_read_packet;
                got.start_cad       = i_start_cad;
                got.start_tx        = i_start_tx;
                got.start_rx        = i_start_rx;
                got.rx_long_timeout = i_rx_long_timeout;
                if (expected_results.size() == 0) begin
                    $error("result beat with no event waiting");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("new_mode", 32'(want.new_mode), 32'(got.new_mode));
                    check_field("clear_bits", 32'(want.clear_bits), 32'(got.clear_bits));
                    check_field("read_packet", 32'(want.read_packet), 32'(got.read_packet));
                    check_field("start_cad", 32'(want.start_cad), 32'(got.start_cad));
                    check_field("start_tx", 32'(want.start_tx), 32'(got.start_tx));
                    check_field("start_rx", 32'(want.start_rx), 32'(got.start_rx));
                    check_field("rx_long_timeout", 32'(want.rx_long_timeout),
                                32'(got.rx_long_timeout));
                    checked++;
                end
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

### dv/tb_radio_link_mode_sequencer.sv
// testbench top for the radio link mode sequencer
// drives events, register writes and result stalls, and gives the verdict; uses rlms_pkg,
// rlms_checker and the block itself
`timescale 1ns / 1ps

module tb_radio_link_mode_sequencer;

    import rlms_pkg::*;

    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 230;
    localparam int HOLD_CYCLES     = 64;
    localparam int LIMIT_CYCLES    = 200000;

    // indexes past the last register, writes there must be dropped
    localparam logic [IDX_W-1:0] REG_VOID_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_VOID_HI = 3'd7;

    localparam logic [IRQ_W-1:0] S_PRE      = IRQ_W'(1 << B_PREAMBLE);
    localparam logic [IRQ_W-1:0] S_RXDONE   = IRQ_W'(1 << B_RXDONE);
    localparam logic [IRQ_W-1:0] S_HDRVALID = IRQ_W'(1 << B_HDRVALID);
    localparam logic [IRQ_W-1:0] S_CRCERR   = IRQ_W'(1 << B_CRCERR);
    localparam logic [IRQ_W-1:0] S_HDRERR   = IRQ_W'(1 << B_HDRERR);
    localparam logic [IRQ_W-1:0] S_RXTMO    = IRQ_W'(1 << B_RXTIMEOUT);
    localparam logic [IRQ_W-1:0] S_TXDONE   = IRQ_W'(1 << B_TXDONE);
    localparam logic [IRQ_W-1:0] S_TXTMO    = IRQ_W'(1 << B_TXTIMEOUT);
    localparam logic [IRQ_W-1:0] S_ACTIVITY = IRQ_W'(1 << B_ACTIVITY);
    localparam logic [IRQ_W-1:0] S_CADDONE  = IRQ_W'(1 << B_CADDONE);
    localparam logic [IRQ_W-1:0] S_ALL      = '1;
    localparam logic [IRQ_W-1:0] S_NONE     = '0;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_stall;
    logic [TIME_W-1:0]    i_now_ms     = '0;
    logic                 i_irq_line   = 1'b0;
    logic [IRQ_W-1:0]     i_irq_bits   = '0;
    logic                 i_tx_pending = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall  = 1'b0;
    logic [MODE_W-1:0]    o_new_mode;
    logic [IRQ_W-1:0]     o_clear_bits;
    logic                 o_read_packet;
    logic                 o_start_cad;
    logic                 o_start_tx;
    logic                 o_start_rx;
    logic                 o_rx_long_timeout;
    logic                 i_cfg_we     = 1'b0;
    logic [IDX_W-1:0]     i_cfg_idx    = '0;
    logic [REG_W-1:0]     i_cfg_data   = '0;

    int                   fail_count;
    int                   pending;
    int                   checked;
    int                   events_sent = 0;
    int                   cycle_count = 0;
    int                   hold_left   = 0;
    logic                 hold_req    = 1'b0;
    logic                 gaps_on     = 1'b1;
    logic [TIME_W-1:0]    clock_ms    = '0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    radio_link_mode_sequencer u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_now_ms          (i_now_ms),
        .i_irq_line        (i_irq_line),
        .i_irq_bits        (i_irq_bits),
        .i_tx_pending      (i_tx_pending),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_new_mode        (o_new_mode),
        .o_clear_bits      (o_clear_bits),
        .o_read_packet     (o_read_packet),
        .o_start_cad       (o_start_cad),
        .o_start_tx        (o_start_tx),
        .o_start_rx        (o_start_rx),
        .o_rx_long_timeout (o_rx_long_timeout),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    rlms_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_now_ms          (i_now_ms),
        .i_irq_line        (i_irq_line),
        .i_irq_bits        (i_irq_bits),
        .i_tx_pending      (i_tx_pending),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_new_mode        (o_new_mode),
        .i_clear_bits      (o_clear_bits),
        .i_read_packet     (o_read_packet),
        .i_start_cad       (o_start_cad),
        .i_start_tx        (o_start_tx),
        .i_start_rx        (o_start_rx),
        .i_rx_long_timeout (o_rx_long_timeout),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked)
    );

    // offers one event beat and returns at the edge that takes it
    task automatic send_event(input logic [TIME_W-1:0] now, input logic line,
                              input logic [IRQ_W-1:0] bits, input logic tx_pend);
        int gap;
        gap = (gaps_on && $urandom_range(99) < 21) ? $urandom_range(1, 3) : 0;
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_now_ms     <= now;
        i_irq_line   <= line;
        i_irq_bits   <= bits;
        i_tx_pending <= tx_pend;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        events_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [REG_W-1:0] rx_restart,
                                 input logic [REG_W-1:0] tx_tmo,
                                 input logic [REG_W-1:0] busy_tmo,
                                 input logic [REG_W-1:0] tx_guard,
                                 input logic [REG_W-1:0] cad_rx,
                                 input logic [REG_W-1:0] def_rx);
        write_reg(REG_RX_RESTART, rx_restart);
        write_reg(REG_VOID_LO, REG_W'($urandom_range(65535)));
        write_reg(REG_TX_TIMEOUT, tx_tmo);
        write_reg(REG_BUSY_TMO, busy_tmo);
        write_reg(REG_TX_GUARD, tx_guard);
        write_reg(REG_CAD_RX_TMO, cad_rx);
        write_reg(REG_VOID_HI, REG_W'($urandom_range(65535)));
        write_reg(REG_DEF_RX_TMO, def_rx);
        i_cfg_we <= 1'b0;
    endtask

    // result side: random stalls, plus one long hold-off when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= gaps_on && ($urandom_range(99) < 21);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("radio_link_mode_sequencer test failed");
            $finish;
        end
    end

    initial begin
        int               roll;
        logic             line;
        logic [IRQ_W-1:0] bits;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed walk through every mode at reset register values
        send_event(32'd0,    1'b0, S_NONE, 1'b0);
        send_event(32'd501,  1'b0, S_ALL,  1'b0);
        send_event(32'd600,  1'b1, S_PRE,  1'b0);
        send_event(32'd1101, 1'b0, S_NONE, 1'b0);
        send_event(32'd1102, 1'b0, S_NONE, 1'b0);
        send_event(32'd1150, 1'b1, S_PRE | S_HDRVALID, 1'b0);
        send_event(32'd1200, 1'b1, S_RXDONE | S_HDRVALID, 1'b0);
        send_event(32'd1210, 1'b1, S_RXDONE | S_HDRVALID | S_CRCERR, 1'b0);
        send_event(32'd1220, 1'b1, S_HDRERR, 1'b0);
        send_event(32'd1230, 1'b1, S_RXTMO,  1'b0);
        send_event(32'd1300, 1'b0, S_NONE,   1'b1);
        send_event(32'd1310, 1'b1, S_CADDONE, 1'b1);
        send_event(32'd1811, 1'b0, S_NONE,   1'b0);
        send_event(32'd1900, 1'b1, S_TXDONE, 1'b1);
        send_event(32'd1902, 1'b0, S_NONE,   1'b1);
        send_event(32'd1905, 1'b1, S_ACTIVITY, 1'b0);
        send_event(32'd1906, 1'b1, S_ACTIVITY, 1'b1);
        send_event(32'd1910, 1'b1, S_CADDONE, 1'b0);
        send_event(32'd1920, 1'b1, S_TXTMO,  1'b1);
        send_event(32'hFFFF_FFFF, 1'b1, S_ALL,  1'b1);
        send_event(32'h0000_0004, 1'b1, S_ALL,  1'b0);
        send_event(32'h8000_0000, 1'b1, S_NONE, 1'b1);
        send_event(32'h7FFF_FFFF, 1'b0, S_ALL,  1'b1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            gaps_on = (ph != 3);
            case (ph)
                0: load_settings(16'd1, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0);
                1: begin
                    load_settings('1, '1, '1, '1, '1, '1);
                    clock_ms = 32'hFFFF_0000;
                end
                2, 3: load_settings(REG_W'($urandom_range(1, 800)),
                                    REG_W'($urandom_range(1, 800)),
                                    REG_W'($urandom_range(1, 800)),
                                    REG_W'($urandom_range(30)),
                                    REG_W'($urandom_range(65535)),
                                    REG_W'($urandom_range(65535)));
                4: load_settings(REG_W'($urandom_range(65535)),
                                 REG_W'($urandom_range(65535)),
                                 REG_W'($urandom_range(65535)),
                                 REG_W'($urandom_range(65535)),
                                 REG_W'($urandom_range(65535)),
                                 REG_W'($urandom_range(65535)));
                // zero timeouts: any positive age counts as expired
                default: load_settings('0, '0, '0, '0, '0, '0);
            endcase

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 2 && n == 100)
                    hold_req = 1'b1;

                roll = $urandom_range(99);
                if (roll < 40)
                    clock_ms = clock_ms + TIME_W'($urandom_range(3));
                else if (roll < 70)
                    clock_ms = clock_ms + TIME_W'($urandom_range(700));
                else if (roll < 85)
                    clock_ms = clock_ms + TIME_W'($urandom_range(70000));
                else if (roll < 95)
                    clock_ms = $urandom;
                else
                    clock_ms = clock_ms - TIME_W'($urandom_range(50));

                // mostly plausible status patterns, some noise
                roll = $urandom_range(99);
                line = 1'b1;
                bits = S_NONE;
                if (roll < 15) begin
                    line = 1'b0;
                    bits = IRQ_W'($urandom_range(1023));
                end else if (roll < 25) begin
                    bits = S_NONE;
                end else if (roll < 40) begin
                    bits = S_PRE | ($urandom_range(1) ? S_HDRVALID : S_NONE);
                end else if (roll < 55) begin
                    bits = S_RXDONE | S_HDRVALID;
                    if ($urandom_range(1)) bits = bits | S_PRE;
                    if ($urandom_range(4) == 0) bits = bits | S_CRCERR;
                end else if (roll < 63) begin
                    case ($urandom_range(2))
                        0: bits = S_HDRERR;
                        1: bits = S_CRCERR;
                        default: bits = S_RXTMO;
                    endcase
                end else if (roll < 73) begin
                    bits = $urandom_range(1) ? S_TXDONE : S_TXTMO;
                end else if (roll < 81) begin
                    bits = S_ACTIVITY;
                end else if (roll < 91) begin
                    bits = S_CADDONE;
                end else begin
                    bits = IRQ_W'($urandom_range(1023));
                end

                send_event(clock_ms, line, bits, 1'($urandom_range(1)));
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);

        $display("covered %0d events over %0d register settings, %0d results checked",
                 events_sent, NUM_PHASES + 1, checked);
        $display("settings spanned zero and full-scale limits, with time wrap and a %0d-cycle hold",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("radio_link_mode_sequencer test passed");
        else
            $display("radio_link_mode_sequencer test failed");
        $finish;
    end

endmodule
